// ===== src/ordered_list_append_remove_macros.svh =====
// Assertion macros used by the checker file of the ordered list block.
// Depends on nothing; include by bare file name.
`ifndef ORDERED_LIST_APPEND_REMOVE_MACROS_SVH
`define ORDERED_LIST_APPEND_REMOVE_MACROS_SVH

// same-cycle implication
`define OLAR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olar assertion failed");

// next-cycle implication
`define OLAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olar assertion failed");

`endif

// ===== src/olar_pkg.sv =====
// Types, codes and sizing constants of the ordered list block.
// Used by every module of the block; depends on nothing.
package olar_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FILL_W   = 6;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_LISTED    = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [2:0]         status;
    logic               last_of_run;
    logic [FILL_W-1:0]  fill_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_RSCAN,
    S_RDONE,
    S_EMIT,
    S_DREAD,
    S_DEMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic empty;
    logic append;
    logic scan;
    logic rdone;
    logic emit;
    logic dread;
    logic demit;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic dump_last;
    logic out_free;
  } stat_t;

endpackage

// ===== src/ordered_list_append_remove.sv =====
// Top level of the ordered list block: joins controller and datapath.
// Depends on olar_pkg, olar_ctrl and olar_dp.
//
// Keeps up to CAPACITY signed 32-bit values in arrival order in an entry memory
// with one write port and one registered read port (one write and one read per
// cycle). An append goes from the accepting state through S_APPEND to S_EMIT,
// which loads the output register once it is free. A remove walks the stored
// list once from the head in S_RSCAN, reading one entry and closing up the gap
// one entry per cycle, then sets its status in S_RDONE and emits from S_EMIT.
// A dump reads the first entry in S_DREAD, then gives one entry per cycle from
// S_DEMIT while the output is free, or the single empty result from S_EMIT.
// The block takes a new item only when the previous one has finished; its last
// result may still sit in the output register while the next item is accepted.
// Mode 3 is accepted and gives no result.
module ordered_list_append_remove (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  olar_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output olar_pkg::rsp_t  rsp
);
  import olar_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  olar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_mode  (req.mode),
    .stat      (stat),
    .cmd       (cmd)
  );

  olar_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_value (req.value),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== src/olar_ctrl.sv =====
// Controller of the ordered list: sequences append, remove scan and dump.
// Depends on olar_pkg; drives commands to olar_dp and reads its status.
module olar_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  logic [1:0]     req_mode,
  input  olar_pkg::stat_t stat,
  output olar_pkg::cmd_t  cmd
);
  import olar_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load = 1'b1;
          unique case (req_mode)
            MODE_APPEND: state_next = S_APPEND;
            MODE_REMOVE: state_next = S_RSCAN;
            MODE_DUMP: begin
              if (stat.count_zero) begin
                cmd.empty  = 1'b1;
                state_next = S_EMIT;
              end else begin
                state_next = S_DREAD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_EMIT;
      end
      S_RSCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_RDONE;
        end
      end
      S_RDONE: begin
        cmd.rdone  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DREAD: begin
        cmd.dread  = 1'b1;
        state_next = S_DEMIT;
      end
      S_DEMIT: begin
        if (stat.out_free) begin
          cmd.demit = 1'b1;
          if (stat.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/olar_dp.sv =====
// Datapath of the ordered list: entry memory, count, scan pointers, output register.
// Depends on olar_pkg; steered by olar_ctrl through cmd_t.
module olar_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  req_value,
  input  olar_pkg::cmd_t      cmd,
  output olar_pkg::stat_t     stat,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output olar_pkg::rsp_t      rsp
);
  import olar_pkg::*;

  logic signed [31:0] mem [CAPACITY];

  logic signed [31:0] val;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ridx;
  logic [IDX_W-1:0]   pidx;
  logic               pv;
  logic               found;
  logic signed [31:0] rdata;
  logic signed [31:0] res_value;
  logic [2:0]         res_status;

  logic [CNT_W-1:0]   ridx_inc;
  logic               full;
  logic               scan_rd;
  logic               scan_wr;
  logic               hit;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic signed [31:0] wdata;
  logic               re;
  logic [IDX_W-1:0]   raddr;

  always_comb begin
    ridx_inc = ridx + CNT_W'(1);
    full     = (count == CNT_W'(CAPACITY));
    scan_rd  = cmd.scan && (ridx < count);
    scan_wr  = cmd.scan && pv && found;
    hit      = cmd.scan && pv && !found && (rdata == val);
    we       = (cmd.append && !full) || scan_wr;
    waddr    = cmd.append ? count[IDX_W-1:0] : pidx - IDX_W'(1);
    wdata    = cmd.append ? val : rdata;
    re       = scan_rd || cmd.dread || (cmd.demit && (ridx_inc < count));
    raddr    = cmd.demit ? ridx_inc[IDX_W-1:0] : ridx[IDX_W-1:0];

    stat.count_zero = (count == '0);
    stat.scan_done  = !(ridx < count) && !pv;
    stat.dump_last  = (ridx_inc == count);
    stat.out_free   = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ridx      <= '0;
      pv        <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        ridx  <= '0;
        pv    <= 1'b0;
        found <= 1'b0;
      end
      if (cmd.scan) begin
        pv <= scan_rd;
        if (scan_rd) begin
          ridx <= ridx_inc;
        end
        if (hit) begin
          found <= 1'b1;
        end
      end
      if (cmd.demit) begin
        ridx <= ridx_inc;
      end
      if (cmd.append && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.rdone && found) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.emit || cmd.demit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= req_value;
    end
    if (scan_rd) begin
      pidx <= ridx[IDX_W-1:0];
    end
    if (cmd.empty) begin
      res_value  <= '0;
      res_status <= ST_LISTED;
    end
    if (cmd.append) begin
      res_value  <= val;
      res_status <= full ? ST_FULL : ST_ADDED;
    end
    if (cmd.rdone) begin
      res_value  <= val;
      res_status <= found ? ST_REMOVED : ST_NOT_FOUND;
    end
    if (cmd.emit) begin
      rsp.item_value  <= res_value;
      rsp.status      <= res_status;
      rsp.last_of_run <= 1'b1;
      rsp.fill_count  <= FILL_W'(count);
    end
    if (cmd.demit) begin
      rsp.item_value  <= rdata;
      rsp.status      <= ST_LISTED;
      rsp.last_of_run <= stat.dump_last;
      rsp.fill_count  <= FILL_W'(count);
    end
  end

endmodule

// ===== src/olar_checker.sv =====
// Port-level checks of the ordered list block, bound to its top level.
// Depends on olar_pkg and ordered_list_append_remove_macros.svh.
`include "ordered_list_append_remove_macros.svh"

module olar_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input olar_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input olar_pkg::rsp_t rsp
);
  import olar_pkg::*;

  `OLAR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `OLAR_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall && (req.mode == MODE_APPEND || req.mode == MODE_REMOVE || req.mode == MODE_DUMP), req_stall)
  `OLAR_ASSERT_NOW(a_single_result, clk, rst, rsp_valid && rsp.status != ST_LISTED, rsp.last_of_run)
  `OLAR_ASSERT_NOW(a_status_code, clk, rst, rsp_valid, rsp.status <= ST_LISTED)

endmodule

bind ordered_list_append_remove olar_checker u_olar_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking bench for the ordered list block: random and directed appends,
// removes and dumps, with results predicted by a shadow list in a scoreboard.
// Depends on olar_pkg and ordered_list_append_remove.
`timescale 1ns / 100ps

class list_scoreboard;
  logic signed [31:0] held [$];
  olar_pkg::rsp_t     pending [$];
  int errors, checked, peak_fill, full_drops, remove_hits, remove_misses;

  function void owe(logic signed [31:0] val, logic [2:0] st, logic last);
    olar_pkg::rsp_t r;
    int n;
    n = held.size();
    r.item_value  = val;
    r.status      = st;
    r.last_of_run = last;
    r.fill_count  = n[olar_pkg::FILL_W-1:0];
    pending.push_back(r);
  endfunction

  function void note_item(olar_pkg::req_t r);
    int hit;
    hit = -1;
    case (r.mode)
      olar_pkg::MODE_APPEND: begin
        if (held.size() < olar_pkg::CAPACITY) begin
          held.push_back(r.value);
          owe(r.value, olar_pkg::ST_ADDED, 1'b1);
        end else begin
          full_drops++;
          owe(r.value, olar_pkg::ST_FULL, 1'b1);
        end
        if (held.size() > peak_fill) peak_fill = held.size();
      end
      olar_pkg::MODE_REMOVE: begin
        for (int i = 0; i < held.size(); i++) begin
          if (held[i] == r.value) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          held.delete(hit);
          remove_hits++;
          owe(r.value, olar_pkg::ST_REMOVED, 1'b1);
        end else begin
          remove_misses++;
          owe(r.value, olar_pkg::ST_NOT_FOUND, 1'b1);
        end
      end
      olar_pkg::MODE_DUMP: begin
        if (held.size() == 0) owe(32'sd0, olar_pkg::ST_LISTED, 1'b1);
        else foreach (held[i]) owe(held[i], olar_pkg::ST_LISTED, i == held.size() - 1);
      end
      default: ;
    endcase
  endfunction

  function void check_result(olar_pkg::rsp_t got);
    olar_pkg::rsp_t want;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: value %0d status %0d last %0b fill %0d",
                 got.item_value, got.status, got.last_of_run, got.fill_count);
      return;
    end
    want = pending.pop_front();
    if (got.item_value !== want.item_value || got.status !== want.status ||
        got.last_of_run !== want.last_of_run || got.fill_count !== want.fill_count) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected value %0d status %0d last %0b fill %0d, got %0d %0d %0b %0d",
                 want.item_value, want.status, want.last_of_run, want.fill_count,
                 got.item_value, got.status, got.last_of_run, got.fill_count);
    end
  endfunction
endclass

module tb_top;
  import olar_pkg::*;

  localparam logic [1:0]         MODE_UNUSED = 2'd3;
  localparam logic signed [31:0] MIN_VAL     = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_VAL     = 32'sh7fff_ffff;
  localparam int                 ITEM_GOAL   = 460;

  typedef enum int {EP_FILL, EP_DRAIN, EP_MIX} episode_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int n_items, n_append, n_remove, n_dump, n_ignored;
  list_scoreboard sb = new;

  always #4 clk = ~clk;

  ordered_list_append_remove i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always @(posedge clk) begin
    rsp_stall <= sink_idle && ($urandom_range(99) < 32);
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  task automatic send_item(input logic [1:0] item_mode, input logic signed [31:0] item_val);
    req_t r;
    r.mode  = item_mode;
    r.value = item_val;
    while (src_idle && $urandom_range(99) < 32) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_item(r);
    case (item_mode)
      MODE_APPEND: n_append++;
      MODE_REMOVE: n_remove++;
      MODE_DUMP:   n_dump++;
      default:     n_ignored++;
    endcase
    if (item_mode != MODE_UNUSED) n_items++;
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    case ($urandom_range(3))
      0, 1: begin
        r = $urandom_range(15);
        return r - 8;
      end
      2: return $urandom;
      default: begin
        case ($urandom_range(3))
          0:       return MIN_VAL;
          1:       return MAX_VAL;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // prefer values that are actually held so removes hit
  function automatic logic signed [31:0] pick_victim();
    if (sb.held.size() != 0 && $urandom_range(99) < 65)
      return sb.held[$urandom_range(sb.held.size() - 1)];
    return pick_value();
  endfunction

  initial begin
    episode_t kind;
    int       ep_len;
    int       roll;
    bit       pressed;
    pressed = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(MODE_DUMP, 32'sd0);
    send_item(MODE_REMOVE, 32'sd5);
    send_item(MODE_UNUSED, -32'sd1);
    send_item(MODE_APPEND, MIN_VAL);
    send_item(MODE_APPEND, MAX_VAL);
    send_item(MODE_APPEND, 32'sd0);
    send_item(MODE_APPEND, -32'sd1);
    send_item(MODE_APPEND, 32'sd7);
    send_item(MODE_APPEND, 32'sd7);
    send_item(MODE_APPEND, 32'sd3);
    send_item(MODE_DUMP, -32'sd1);
    send_item(MODE_REMOVE, 32'sd7);
    send_item(MODE_DUMP, 32'sd0);
    send_item(MODE_REMOVE, 32'sd12345);
    send_item(MODE_REMOVE, MIN_VAL);
    send_item(MODE_REMOVE, 32'sd3);
    send_item(MODE_DUMP, 32'sd0);
    send_item(MODE_REMOVE, MAX_VAL);
    send_item(MODE_REMOVE, 32'sd0);
    send_item(MODE_REMOVE, -32'sd1);
    send_item(MODE_REMOVE, 32'sd7);
    send_item(MODE_DUMP, 32'sd0);
    hold_until_drained();

    // run into the full list and overflow it
    repeat (CAPACITY + 4) send_item(MODE_APPEND, pick_value());
    send_item(MODE_DUMP, pick_value());

    while (n_items < ITEM_GOAL) begin
      kind   = episode_t'($urandom_range(2));
      ep_len = $urandom_range(10, 50);
      repeat (ep_len) begin
        src_idle  = !(n_items >= 200 && n_items < 320);
        sink_idle = src_idle;
        roll = $urandom_range(99);
        if (roll < 2) send_item(MODE_UNUSED, pick_value());
        else begin
          case (kind)
            EP_FILL:  roll = (roll < 75) ? 0 : (roll < 90) ? 1 : 2;
            EP_DRAIN: roll = (roll < 15) ? 0 : (roll < 80) ? 1 : 2;
            default:  roll = (roll < 40) ? 0 : (roll < 80) ? 1 : 2;
          endcase
          case (roll)
            0:       send_item(MODE_APPEND, pick_value());
            1:       send_item(MODE_REMOVE, pick_victim());
            default: send_item(MODE_DUMP, pick_value());
          endcase
        end
      end
      if (!pressed && n_items > 250) begin
        hold_until_drained();
        pressed = 1'b1;
      end
    end

    hold_until_drained();
    repeat (80) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0d results never arrived", sb.pending.size());
    end
    $display("covered %0d items: %0d appends, %0d removes, %0d dumps, plus %0d unused-mode items",
             n_items, n_append, n_remove, n_dump, n_ignored);
    $display("checked %0d results; peak fill %0d, %0d full drops, %0d removes hit, %0d missed",
             sb.checked, sb.peak_fill, sb.full_drops, sb.remove_hits, sb.remove_misses);
    if (sb.errors == 0) begin
      $display("** ordered_list_append_remove: PASSED **");
    end else begin
      $display("%0d errors", sb.errors);
      $display("** ordered_list_append_remove: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("run timed out");
    $display("** ordered_list_append_remove: FAILED **");
    $finish;
  end

endmodule

// ===== ordered_list_append_remove.f =====
+incdir+src
src/olar_pkg.sv
src/olar_ctrl.sv
src/olar_dp.sv
src/ordered_list_append_remove.sv
src/olar_checker.sv
dv/tb_top.sv
